### rtl/core/apr_pkg.sv
// Package: shared types and constants for the aging page replacement block.
package apr_pkg;

  localparam int PAGE_IN_W   = 20;
  localparam int FRAME_OUT_W = 7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } apr_state_t;

  typedef struct packed {
    logic capture;
    logic clr;
    logic rd;
    logic commit;
  } apr_cmd_t;

endpackage

### rtl/core/apr_ifs.sv
// Interfaces: page reference request channel and replacement response channel.
interface apr_req_if import apr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [PAGE_IN_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface apr_rsp_if import apr_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [FRAME_OUT_W-1:0] frame_index;

  modport source (output valid, output hit, output frame_index, input ready);
  modport sink   (input valid, input hit, input frame_index, output ready);
endinterface

### rtl/core/apr_ctrl.sv
// Controller: sequences the clearing pass, the frame scan and the response beat.
module apr_ctrl import apr_pkg::*; #(
  parameter int NUM_FRAMES = 128,
  parameter int FW         = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output apr_cmd_t      cmd,
  output logic [FW-1:0] addr
);

  localparam logic [FW-1:0] LAST = FW'(NUM_FRAMES - 1);

  apr_state_t    state;
  apr_state_t    state_next;
  logic [FW-1:0] idx;
  logic [FW-1:0] idx_next;
  logic          out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr  = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          idx_next    = '0;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd   = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid || rsp_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        idx_next   = '0;
      end
    endcase
  end

  assign addr      = idx;
  assign rsp_valid = out_valid;

`ifndef SYNTH
  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("response beat not raised after commit");

  a_capture_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_SCAN) && (idx == '0))
    else $error("scan did not start at frame zero");

  a_scan_end_drains: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (idx == LAST) |=> (state == ST_DRAIN))
    else $error("scan did not drain after last frame");
`endif

endmodule

### rtl/core/apr_dp.sv
// Datapath: tag and age memories, lookup and victim tracking, response registers.
module apr_dp import apr_pkg::*; #(
  parameter int NUM_FRAMES = 128,
  parameter int AGE_BITS   = 8,
  parameter int PAGE_BITS  = 20,
  parameter int FW         = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  apr_cmd_t               cmd,
  input  logic [FW-1:0]          addr,
  input  logic [PAGE_IN_W-1:0]   page_in,
  output logic                   hit_out,
  output logic [FRAME_OUT_W-1:0] frame_out
);

  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS - 1){1'b0}}};

  logic [PAGE_BITS:0]    tag_mem [NUM_FRAMES];
  logic [AGE_BITS-1:0]   age_mem [NUM_FRAMES];
  logic [PAGE_BITS:0]    tag_rd;
  logic [AGE_BITS-1:0]   age_rd;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  s1_valid;
  logic [FW-1:0]         s1_idx;
  logic                  pend;
  logic                  pend_hit;
  logic [FW-1:0]         pend_idx;
  logic                  found;
  logic [FW-1:0]         hit_idx;
  logic [FW-1:0]         min_idx;
  logic [AGE_BITS-1:0]   best;
  logic                  match;
  logic                  first;
  logic [AGE_BITS-1:0]   aged;
  logic [FW-1:0]         used;
  logic                  tag_we;
  logic [FW-1:0]         tag_wa;
  logic [PAGE_BITS:0]    tag_wd;
  logic                  age_we;
  logic [FW-1:0]         age_wa;
  logic [AGE_BITS-1:0]   age_wd;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      tag_rd <= tag_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      age_rd <= age_mem[addr];
    end
  end

  always_comb begin
    first = (s1_idx == '0);
    match = tag_rd[PAGE_BITS] && (tag_rd[PAGE_BITS-1:0] == page_q);
    if (pend && (s1_idx == pend_idx)) begin
      aged = pend_hit ? ((age_rd >> 1) | AGE_TOP) : AGE_TOP;
    end else if (pend) begin
      aged = age_rd >> 1;
    end else begin
      aged = age_rd;
    end
    used   = found ? hit_idx : min_idx;
    tag_we = cmd.clr || cmd.commit;
    tag_wa = cmd.commit ? used : addr;
    tag_wd = cmd.commit ? {1'b1, page_q} : '0;
    age_we = cmd.clr || s1_valid;
    age_wa = cmd.clr ? addr : s1_idx;
    age_wd = cmd.clr ? '0 : aged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pend     <= 1'b0;
    end else begin
      s1_valid <= cmd.rd;
      if (cmd.commit) begin
        pend <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= addr;
    if (cmd.capture) begin
      page_q <= PAGE_BITS'(page_in);
    end
    if (s1_valid) begin
      if (first) begin
        found   <= match;
        hit_idx <= s1_idx;
        min_idx <= s1_idx;
        best    <= aged;
      end else begin
        if (match && !found) begin
          found   <= 1'b1;
          hit_idx <= s1_idx;
        end
        if (aged < best) begin
          best    <= aged;
          min_idx <= s1_idx;
        end
      end
    end
    if (cmd.commit) begin
      pend_idx  <= used;
      pend_hit  <= found;
      hit_out   <= found;
      frame_out <= FRAME_OUT_W'(used);
    end
  end

`ifndef SYNTH
  a_clear_not_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> !s1_valid)
    else $error("clearing write overlaps scan write-back");

  a_commit_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !s1_valid && !cmd.rd)
    else $error("commit while scan still in flight");

  a_read_feeds_stage: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> s1_valid && (s1_idx == $past(addr)))
    else $error("scan stage lost a frame read");
`endif

endmodule

### rtl/core/aging_page_replacement.sv
// Top level: aging page replacement over NUM_FRAMES frames.
// Each page reference is served by a scan that reads one frame per cycle
// from the tag and age memories, checks for a resident match, tracks the
// smallest age (lowest index on ties) and writes back the aged counter of the
// previous reference in the same pass. A new reference is accepted once the
// previous one has been committed to the response register; the response beat
// then waits there for the sink. After reset a clearing pass over all
// NUM_FRAMES frames empties both memories, with req.ready held low until it ends.
module aging_page_replacement import apr_pkg::*; #(
  parameter int NUM_FRAMES = 128,
  parameter int AGE_BITS   = 8,
  parameter int PAGE_BITS  = 20
) (
  input  logic      clk,
  input  logic      rst,
  apr_req_if.sink   req,
  apr_rsp_if.source rsp
);

  localparam int FW = $clog2(NUM_FRAMES);

  apr_cmd_t      cmd;
  logic [FW-1:0] addr;

  apr_ctrl #(
    .NUM_FRAMES (NUM_FRAMES),
    .FW         (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .addr      (addr)
  );

  apr_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .AGE_BITS   (AGE_BITS),
    .PAGE_BITS  (PAGE_BITS),
    .FW         (FW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .page_in   (req.page_number),
    .hit_out   (rsp.hit),
    .frame_out (rsp.frame_index)
  );

endmodule
